// ===== rtl/grid_rectangle_first_fit_core_defines.svh =====
// Assertion macros for the top level of the grid rectangle first-fit RTL.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef GRID_RECTANGLE_FIRST_FIT_CORE_DEFINES_SVH
`define GRID_RECTANGLE_FIRST_FIT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRF_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/grf_pkg.sv =====
// Shared types and constants for the grid rectangle first-fit allocator.
// No dependencies; imported by every module of the block.
package grf_pkg;

	localparam int DIM_W  = 4;   // rectangle width / height field
	localparam int SLOT_W = 7;   // linear slot field

	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// Command from the sequencer to the occupancy map.
	typedef struct packed {
		logic clr;   // empty the whole map
		logic wr;    // write one row
	} map_cmd_t;

endpackage

// ===== rtl/grf_occ_map.sv =====
// Occupancy bitmap, one register row per grid row, one read and one write row port.
// Depends on grf_pkg.
module grf_occ_map import grf_pkg::*; #(
	parameter int COLS   = 8,
	parameter int ROWS   = 15,
	parameter int RIDX_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  map_cmd_t          cmd,
	input  logic [RIDX_W-1:0] addr,
	input  logic [COLS-1:0]   wr_row,
	output logic [COLS-1:0]   rd_row
);

	logic [COLS-1:0] rows_q [ROWS];

	assign rd_row = rows_q[addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) rows_q[r] <= '0;
		end else if (cmd.clr) begin
			for (int r = 0; r < ROWS; r++) rows_q[r] <= '0;
		end else if (cmd.wr) begin
			rows_q[addr] <= wr_row;
		end
	end

endmodule

// ===== rtl/grf_fit_unit.sv =====
// Shared row test unit: builds the column mask of a rectangle, checks it
// against one map row and produces the row with the mask merged in. Depends on grf_pkg.
module grf_fit_unit import grf_pkg::*; #(
	parameter int COLS   = 8,
	parameter int CIDX_W = 3
) (
	input  logic [CIDX_W-1:0] col,
	input  logic [DIM_W-1:0]  w,
	input  logic [COLS-1:0]   rd_row,
	output logic              hit,
	output logic [COLS-1:0]   merged
);

	localparam int CB_W = CIDX_W + DIM_W + 1;

	logic [CB_W-1:0] col_end;
	logic [COLS-1:0] mask;

	assign col_end = CB_W'(col) + CB_W'(w);

	always_comb begin
		for (int i = 0; i < COLS; i++) begin
			mask[i] = (CB_W'(i) >= CB_W'(col)) && (CB_W'(i) < col_end);
		end
	end

	assign hit    = |(rd_row & mask);
	assign merged = rd_row | mask;

endmodule

// ===== rtl/grid_rectangle_first_fit_core.sv =====
// Top level of the grid rectangle first-fit allocator: sequencer, output register.
// Depends on grf_pkg, grf_occ_map, grf_fit_unit and the assertion macro header.
//
// Use: one request channel (s_*) and one reply channel (m_*), each moving a
// request when tvalid and tready are high at a rising clk edge. A request is
// either a place (tuser = 0, rectangle width and height in tdata) or a clear
// (tuser = 1). Every request yields exactly one reply: tuser = placed, tdata
// = linear anchor slot (column + row * GRID_COLUMNS, low 7 bits), zero when
// nothing was placed.
// Flow: a clear goes straight to the reply state. A place walks the anchors
// row by row, left to right, through one shared row test unit and one map row
// port. Each anchor gets the edge and anchor-free checks; for one that passes,
// the rectangle rows are tested one per cycle until a row hits, and a winner
// then has its rows marked one per cycle before the reply is handed over.
// s_tready is high only while the sequencer idles; one request is in work at a
// time. The reply sits in an output register, so a new request may be taken
// while the previous reply waits; a stalled receiver then holds the sequencer
// in its reply state until the register drains.
// Reset (arst_n low) empties the map and drops any pending reply.
`include "grid_rectangle_first_fit_core_defines.svh"

module grid_rectangle_first_fit_core import grf_pkg::*; #(
	parameter int GRID_COLUMNS = 8,
	parameter int GRID_ROWS    = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [3:0] item_width, [7:4] item_height
	input  logic       s_tuser,   // [0] action
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] slot, [7] zero fill
	output logic       m_tuser    // [0] placed
);

	localparam int CIDX_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
	localparam int RIDX_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CB_W   = CIDX_W + DIM_W + 1;
	localparam int RB_W   = RIDX_W + DIM_W + 1;
	localparam int SF_RAW = RIDX_W + CIDX_W + 1;
	localparam int SF_W   = (SF_RAW > SLOT_W) ? SF_RAW : SLOT_W;

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ANCH = 5'b00010,   // edge check and anchor-free check
		S_SCAN = 5'b00100,   // test one rectangle row per cycle
		S_MARK = 5'b01000,   // mark one rectangle row per cycle
		S_RESP = 5'b10000    // hand the reply to the output register
	} state_t;

	state_t              state_q;
	logic [CIDX_W-1:0]   col_q;
	logic [RIDX_W-1:0]   row_q;
	logic [DIM_W-1:0]    dy_q;
	logic [DIM_W-1:0]    w_q;
	logic [DIM_W-1:0]    h_q;
	logic                found_q;
	logic                m_tvalid_q;
	logic                m_placed_q;
	logic [SLOT_W-1:0]   m_slot_q;

	logic                s_accept;
	logic                resp_load;
	map_cmd_t            map_cmd;
	logic [RB_W-1:0]     row_sum;
	logic [GRID_COLUMNS-1:0] rd_row;
	logic [GRID_COLUMNS-1:0] wr_row;
	logic                hit;
	logic [CB_W-1:0]     col_end;
	logic [RB_W-1:0]     row_end;
	logic                in_bounds;
	logic                anchor_free;
	logic                col_last;
	logic                row_last;
	logic                dy_last;
	logic [SF_W-1:0]     slot_full;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// Load the output register once the previous reply is gone or leaves now.
	assign resp_load = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	// Map row under test: anchor row plus rectangle row offset.
	assign row_sum = RB_W'(row_q) + RB_W'(dy_q);

	assign map_cmd.clr = s_accept && (s_tuser == ACT_CLEAR);
	assign map_cmd.wr  = (state_q == S_MARK);

	grf_occ_map #(
		.COLS   (GRID_COLUMNS),
		.ROWS   (GRID_ROWS),
		.RIDX_W (RIDX_W)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (map_cmd),
		.addr   (row_sum[RIDX_W-1:0]),
		.wr_row (wr_row),
		.rd_row (rd_row)
	);

	grf_fit_unit #(
		.COLS   (GRID_COLUMNS),
		.CIDX_W (CIDX_W)
	) u_fit (
		.col    (col_q),
		.w      (w_q),
		.rd_row (rd_row),
		.hit    (hit),
		.merged (wr_row)
	);

	// Reject rectangles that would cross the right or bottom grid edge.
	assign col_end     = CB_W'(col_q) + CB_W'(w_q);
	assign row_end     = RB_W'(row_q) + RB_W'(h_q);
	assign in_bounds   = (col_end <= CB_W'(GRID_COLUMNS)) && (row_end <= RB_W'(GRID_ROWS));
	assign anchor_free = !rd_row[col_q];

	assign col_last = (col_q == CIDX_W'(GRID_COLUMNS - 1));
	assign row_last = (row_q == RIDX_W'(GRID_ROWS - 1));
	assign dy_last  = (dy_q == h_q - DIM_W'(1));

	assign slot_full = SF_W'(row_q) * SF_W'(GRID_COLUMNS) + SF_W'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			dy_q       <= '0;
			w_q        <= '0;
			h_q        <= '0;
			m_placed_q <= 1'b0;
			m_slot_q   <= '0;
		end else begin
			// Raise the reply when the sequencer hands one over; drop it once taken.
			if (resp_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						col_q   <= '0;
						row_q   <= '0;
						dy_q    <= '0;
						w_q     <= s_tdata[3:0];
						h_q     <= s_tdata[7:4];
						found_q <= 1'b0;
						state_q <= (s_tuser == ACT_CLEAR) ? S_RESP : S_ANCH;
					end
				end
				S_ANCH: begin
					if (in_bounds && anchor_free) begin
						// Zero height covers no row: take the anchor as is.
						if (h_q == '0) begin
							found_q <= 1'b1;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (col_last && row_last) begin
						state_q <= S_RESP;
					end else begin
						col_q <= col_last ? '0 : col_q + CIDX_W'(1);
						row_q <= col_last ? row_q + RIDX_W'(1) : row_q;
					end
				end
				S_SCAN: begin
					if (hit) begin
						dy_q <= '0;
						if (col_last && row_last) begin
							state_q <= S_RESP;
						end else begin
							col_q   <= col_last ? '0 : col_q + CIDX_W'(1);
							row_q   <= col_last ? row_q + RIDX_W'(1) : row_q;
							state_q <= S_ANCH;
						end
					end else if (dy_last) begin
						dy_q    <= '0;
						state_q <= S_MARK;
					end else begin
						dy_q <= dy_q + DIM_W'(1);
					end
				end
				S_MARK: begin
					if (dy_last) begin
						dy_q    <= '0;
						found_q <= 1'b1;
						state_q <= S_RESP;
					end else begin
						dy_q <= dy_q + DIM_W'(1);
					end
				end
				S_RESP: begin
					// Hold here while the previous reply still waits.
					if (resp_load) begin
						m_placed_q <= found_q;
						m_slot_q   <= found_q ? slot_full[SLOT_W-1:0] : '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_placed_q;
	assign m_tdata  = {1'b0, m_slot_q};

	`GRF_ASSERT_HOLDS(a_rows_in_grid, state_q == S_SCAN || state_q == S_MARK,
		row_sum < RB_W'(GRID_ROWS), "rectangle row outside grid")
	`GRF_ASSERT_HOLDS(a_fail_slot_zero, m_tvalid_q && !m_placed_q, m_slot_q == '0,
		"failed reply with nonzero slot")
	`GRF_ASSERT_NEXT(a_clear_reply, s_accept && s_tuser == ACT_CLEAR,
		state_q == S_RESP && !found_q, "clear did not go to an empty reply")
	`GRF_ASSERT_HOLDS(a_mark_after_scan, state_q == S_MARK,
		$past(state_q == S_SCAN || state_q == S_MARK), "marking without a passed scan")

endmodule

// ===== bench/grf_reply_checker.sv =====
`timescale 1ns / 100ps
// Reply checker for grid_rectangle_first_fit_core: predicts each reply from the
// accepted requests on its own occupancy map and compares. Depends on grf_pkg.
module grf_reply_checker import grf_pkg::*; #(
	parameter int GRID_COLUMNS = 8,
	parameter int GRID_ROWS    = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [3:0] item_width, [7:4] item_height
	input  logic       s_tuser,   // [0] action
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [6:0] slot, [7] zero fill
	input  logic       m_tuser,   // [0] placed
	output int         errors,
	output int         pending
);

	localparam int CELLS = GRID_COLUMNS * GRID_ROWS;

	typedef struct packed {
		logic              placed;
		logic [SLOT_W-1:0] slot;
	} reply_t;

	bit [CELLS-1:0] occupied_cells = '0;
	reply_t         expected_replies[$];

	task automatic report_mismatch(input string what, input logic [7:0] want,
		input logic [7:0] got);
		$display("[%0t] reply mismatch, %s: expected %h, got %h", $realtime, what, want, got);
		errors++;
	endtask

	// First fit over free anchors, row by row, left to right; mark the winner.
	function automatic reply_t first_fit_place(input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h);
		reply_t result;
		bit     fits;
		result = '0;
		for (int row = 0; row < GRID_ROWS; row++) begin
			for (int col = 0; col < GRID_COLUMNS; col++) begin
				if (!occupied_cells[row * GRID_COLUMNS + col] &&
				    col + w <= GRID_COLUMNS && row + h <= GRID_ROWS) begin
					fits = 1'b1;
					for (int dy = 0; dy < h; dy++)
						for (int dx = 0; dx < w; dx++)
							if (occupied_cells[(row + dy) * GRID_COLUMNS + col + dx])
								fits = 1'b0;
					if (fits) begin
						for (int dy = 0; dy < h; dy++)
							for (int dx = 0; dx < w; dx++)
								occupied_cells[(row + dy) * GRID_COLUMNS + col + dx] = 1'b1;
						result.placed = 1'b1;
						result.slot   = SLOT_W'(col + row * GRID_COLUMNS);
						return result;
					end
				end
			end
		end
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t predicted;
		if (!arst_n) begin
			occupied_cells = '0;
			expected_replies.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_CLEAR) begin
					occupied_cells = '0;
					predicted = '0;
				end else begin
					predicted = first_fit_place(s_tdata[3:0], s_tdata[7:4]);
				end
				expected_replies = {expected_replies, predicted};
			end
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("reply with nothing outstanding", 8'h00, m_tdata);
				end else begin
					want = expected_replies.pop_front();
					if (m_tuser !== want.placed)
						report_mismatch("placed", 8'(want.placed), 8'(m_tuser));
					if (m_tdata[SLOT_W-1:0] !== want.slot)
						report_mismatch("slot", 8'(want.slot), 8'(m_tdata[SLOT_W-1:0]));
					if (m_tdata[7] !== 1'b0)
						report_mismatch("zero fill", 8'h00, 8'(m_tdata[7]));
				end
			end
		end
		pending = expected_replies.size();
	end

endmodule

// ===== bench/tb_grid_rectangle_first_fit_core.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for grid_rectangle_first_fit_core: directed corner cases,
// then random fill-and-clear sessions. Depends on grf_pkg, grf_reply_checker and the core.
module tb_grid_rectangle_first_fit_core;
	import grf_pkg::*;

	localparam int GRID_COLUMNS  = 8;
	localparam int GRID_ROWS     = 15;
	localparam int TOTAL_ITEMS   = 1350;
	localparam int HOLD_AT_ITEM  = 400;   // receiver goes quiet around here
	localparam int PAUSE_AT_ITEM = 900;   // sender drains the block around here
	localparam int HOLD_CYCLES   = 3000;
	localparam int DRAIN_CYCLES  = 2048;  // covers the slowest place walk

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;    // [3:0] item_width, [7:4] item_height
	logic       s_tuser  = 1'b0;  // [0] action
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [6:0] slot, [7] zero fill
	logic       m_tuser;          // [0] placed

	int errors;
	int pending;
	int sent_count    = 0;
	int hold_off_asks = 0;        // bumped by the sender, served by the receiver

	grid_rectangle_first_fit_core #(
		.GRID_COLUMNS(GRID_COLUMNS),
		.GRID_ROWS   (GRID_ROWS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	grf_reply_checker #(
		.GRID_COLUMNS(GRID_COLUMNS),
		.GRID_ROWS   (GRID_ROWS)
	) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop: several times the slowest legal run (every place walking the
	// whole grid at the tallest rectangle, plus every stall and gap).
	initial begin
		#100_000_000;
		$display("grid_rectangle_first_fit_core verification failed");
		$finish;
	end

	// Offer one request and hold it until the block takes it. Leave tvalid
	// high on return so back-to-back requests keep the bus busy.
	task automatic send_request(input logic act, input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {h, w};
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic place(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		send_request(ACT_PLACE, w, h);
	endtask

	// Drop tvalid and wait until every outstanding reply has been taken. The
	// extra edge makes sure the last accepted request is already counted.
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// Receiver: runs of always-ready, coin-flip, mostly-ready and fully
	// stalled, plus one long hold-off on request from the sender.
	initial begin
		int mode;
		int run_len;
		int hold_off_done;
		hold_off_done = 0;
		@(posedge clk);
		forever begin
			if (hold_off_asks != hold_off_done) begin
				hold_off_done = hold_off_asks;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode    = $urandom_range(0, 3);
				run_len = $urandom_range(1, 24);
				repeat (run_len) begin
					unique case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) != 0);
						default: m_tready <= 1'b0;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		int  burst_len;
		int  gap;
		int  pick;
		int  session_left;
		bit  hold_asked;
		bit  paused;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;

		hold_asked   = 1'b0;
		paused       = 1'b0;
		session_left = 0;

		// Single reset pulse at the start of the run.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: zero sizes on an empty and a full map, the whole
		// grid, edge crossings in both directions, wide zero-height.
		place(4'd0, 4'd0);     // empty map: first anchor, marks nothing
		place(4'd1, 4'd1);     // same anchor again, now marks it
		place(4'd8, 4'd15);    // whole grid no longer fits
		send_request(ACT_CLEAR, 4'd15, 4'd15);
		place(4'd8, 4'd15);    // whole grid
		place(4'd1, 4'd1);     // full map fails
		place(4'd0, 4'd0);     // zero size on a full map fails too
		place(4'd0, 4'd7);
		send_request(ACT_CLEAR, 4'd0, 4'd0);
		place(4'd9, 4'd1);     // crosses the right edge everywhere
		place(4'd1, 4'd15);
		place(4'd15, 4'd15);
		place(4'd1, 4'd15);
		place(4'd0, 4'd3);     // zero width takes first free anchor
		place(4'd6, 4'd15);    // fills the rest of the grid
		place(4'd3, 4'd0);
		send_request(ACT_CLEAR, 4'd5, 4'd10);
		place(4'd15, 4'd0);    // zero height but too wide: fails
		place(4'd0, 4'd15);    // zero width, full height: row 0 only
		place(4'd8, 4'd1);
		place(4'd2, 4'd14);
		place(4'd4, 4'd4);
		place(4'd7, 4'd1);
		place(4'd5, 4'd10);
		send_request(ACT_CLEAR, 4'd15, 4'd15);
		drain_replies();

		// Random part: fill-and-clear sessions of random length, mostly small
		// rectangles, with noise and zero sizes mixed in. Bursts with random
		// gaps; some bursts run with no gap at all.
		while (sent_count < TOTAL_ITEMS) begin
			burst_len = $urandom_range(1, 24);
			repeat (burst_len) begin
				if (sent_count < TOTAL_ITEMS) begin
					if (session_left == 0) begin
						session_left = $urandom_range(4, 40);
						send_request(ACT_CLEAR, 4'($urandom_range(0, 15)),
							4'($urandom_range(0, 15)));
					end else begin
						session_left--;
						pick = $urandom_range(0, 99);
						if (pick < 8) begin
							// noise over the whole field range
							w = 4'($urandom_range(0, 15));
							h = 4'($urandom_range(0, 15));
						end else if (pick < 13) begin
							// one dimension zero
							w = 4'($urandom_range(0, 15));
							h = 4'($urandom_range(0, 15));
							if ($urandom_range(0, 1)) w = '0;
							else h = '0;
						end else if (pick < 25) begin
							w = 4'($urandom_range(1, GRID_COLUMNS));
							h = 4'($urandom_range(1, GRID_ROWS));
						end else begin
							w = 4'($urandom_range(1, 4));
							h = 4'($urandom_range(1, 4));
						end
						place(w, h);
					end
				end
			end

			// Ask the receiver for its long hold-off and keep sending so the
			// block backs up into its input.
			if (!hold_asked && sent_count >= HOLD_AT_ITEM) begin
				hold_asked = 1'b1;
				hold_off_asks++;
			end

			if (!paused && sent_count >= PAUSE_AT_ITEM) begin
				paused = 1'b1;
				drain_replies();
			end else if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		// Let everything drain, then watch for stray replies a while longer.
		drain_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("grid_rectangle_first_fit_core verification clean");
		end else begin
			$display("grid_rectangle_first_fit_core verification failed");
		end
		$finish;
	end

endmodule
